// File: rtl/core/pcan_pkg.sv
// Shared types and constants for the path canonicalizer.
package pcan_pkg;

    localparam int PATH_BYTES  = 64;
    localparam int STACK_DEPTH = 32;

    localparam int PATH_AW  = $clog2(PATH_BYTES);
    localparam int PATH_LW  = $clog2(PATH_BYTES + 1);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int STACK_CW = $clog2(STACK_DEPTH + 1);
    localparam int COMP_LW  = 7;
    localparam int POS_W    = ((PATH_LW > COMP_LW) ? PATH_LW : COMP_LW) + 1;

    localparam logic [7:0] SLASH = 8'h2F;
    localparam logic [7:0] DOT   = 8'h2E;

    typedef struct packed {
        logic [7:0] path_char;
        logic       path_end;
    } item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic       overflowed;
    } result_t;

    typedef struct packed {
        logic               en;
        logic [PATH_AW-1:0] addr;
        logic [7:0]         data;
    } buf_wr_t;

    typedef struct packed {
        logic               go;
        logic [PATH_LW-1:0] len;
        logic               ovf;
    } drain_cmd_t;

endpackage

// File: rtl/core/pcan_drain.sv
// Path buffer memory and the sequencer that streams the finished path out.
module pcan_drain
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pcan_pkg::buf_wr_t      wr,
    input  pcan_pkg::drain_cmd_t   cmd,
    output logic                   busy,
    output logic                   result_valid,
    output pcan_pkg::result_t      result
);

    typedef enum logic {D_IDLE, D_EMIT} dstate_t;

    logic [7:0] buf_mem [pcan_pkg::PATH_BYTES];
    logic [7:0] rdata_reg;

    dstate_t                      state_reg, state_next;
    logic [pcan_pkg::PATH_LW-1:0] rd_idx_reg, rd_idx_next;
    logic [pcan_pkg::PATH_LW-1:0] cnt_reg, cnt_next;
    logic [pcan_pkg::PATH_LW-1:0] len_reg, len_next;
    logic                         ovf_reg, ovf_next;
    logic                         valid_reg, valid_next;
    pcan_pkg::result_t            result_reg, result_next;

    logic                         rd_en;
    logic [pcan_pkg::PATH_AW-1:0] rd_addr;
    logic [pcan_pkg::PATH_LW-1:0] cnt_inc;
    logic                         is_last;

    assign cnt_inc = cnt_reg + pcan_pkg::PATH_LW'(1);
    assign is_last = (cnt_inc == len_reg);

    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        valid_next  = 1'b0;
        result_next = result_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        case (state_reg)
            D_IDLE:
            begin
                if (cmd.go)
                begin
                    if (cmd.len == '0)
                    begin
                        // nothing kept: emit the root alone
                        result_next = '{out_char: pcan_pkg::SLASH, out_last: 1'b1,
                                        overflowed: cmd.ovf};
                        valid_next  = 1'b1;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_idx_next = pcan_pkg::PATH_LW'(1);
                        cnt_next    = '0;
                        len_next    = cmd.len;
                        ovf_next    = cmd.ovf;
                        state_next  = D_EMIT;
                    end
                end
            end
            D_EMIT:
            begin
                // prefetch the next byte while presenting the current one
                rd_en       = 1'b1;
                rd_addr     = rd_idx_reg[pcan_pkg::PATH_AW-1:0];
                rd_idx_next = rd_idx_reg + pcan_pkg::PATH_LW'(1);
                cnt_next    = cnt_inc;
                result_next = '{out_char: rdata_reg, out_last: is_last, overflowed: ovf_reg};
                valid_next  = 1'b1;
                if (is_last)
                begin
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= D_IDLE;
            rd_idx_reg <= '0;
            cnt_reg    <= '0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            valid_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            valid_reg  <= valid_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            buf_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= buf_mem[rd_addr];
        end
    end

    assign busy         = (state_reg != D_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/core/path_canonicalizer.sv
// Top level of the streaming Unix path canonicalizer.
//
// Usage: present one path byte on item (path_char, path_end) with start high;
// the transfer happens on a rising edge where start is high and busy is low.
// The first byte of every path stands for the leading '/' and is skipped.
// Each '/' and the final byte (path_end = 1) close a component: an empty one
// or "." is dropped, ".." pops the last kept component, anything else is
// pushed onto the start stack and stays in the path buffer while both have room.
// Per transfer: the skipped first byte is taken in S_IDLE alone; a '/' passes
// through S_ENDC; an ordinary byte through S_ADD, which it visits twice when it
// opens a component (the separator goes into the buffer first); a ".." that
// pops adds S_POP for the stack read. These steps come from the single write
// port of the path buffer and the registered read of the start stack.
// On the final byte the canonical path leaves on result, one byte per cycle,
// each marked by result_valid for exactly one cycle with out_last on the final
// byte and the same overflowed flag on all of them. The first byte passes
// the drain's read and result registers; busy stays high as the drain streams.
// The receiver cannot stall; results are simply taken as they come.
// Reset clears the bookkeeping (lengths, counts, flags); the buffer and stack
// memories need no clearing since only entries written for the current path
// are ever read.
module path_canonicalizer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pcan_pkg::item_t     item,
    output logic                result_valid,
    output pcan_pkg::result_t   result
);

    typedef enum logic [1:0] {S_IDLE, S_ADD, S_ENDC, S_POP} state_t;
    typedef enum logic [1:0] {KIND_EMPTY, KIND_DOT, KIND_DOTDOT, KIND_OTHER} kind_t;

    localparam logic [pcan_pkg::COMP_LW-1:0] COMP_MAX = '1;

    state_t                        state_reg, state_next;
    logic [7:0]                    char_reg, char_next;
    logic                          end_reg, end_next;
    logic [pcan_pkg::PATH_LW-1:0]  path_length_reg, path_length_next;
    logic [pcan_pkg::STACK_CW-1:0] stack_count_reg, stack_count_next;
    logic [pcan_pkg::COMP_LW-1:0]  comp_length_reg, comp_length_next;
    kind_t                         comp_kind_reg, comp_kind_next;
    logic                          first_pending_reg, first_pending_next;
    logic                          overflow_reg, overflow_next;

    // start of each kept component inside the path buffer
    logic [pcan_pkg::PATH_AW-1:0]  stack_mem [pcan_pkg::STACK_DEPTH];
    logic [pcan_pkg::PATH_AW-1:0]  stack_rdata_reg;

    logic                          push_en, pop_en;
    logic [pcan_pkg::STACK_AW-1:0] pop_addr;
    logic [pcan_pkg::POS_W-1:0]    wr_pos, avail, comp_ext;
    logic                          accept, drain_busy;
    pcan_pkg::buf_wr_t             buf_wr;
    pcan_pkg::drain_cmd_t          drain_cmd;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE) || drain_busy;
    assign comp_ext = pcan_pkg::POS_W'(comp_length_reg);
    assign avail    = pcan_pkg::POS_W'(pcan_pkg::PATH_BYTES)
                    - pcan_pkg::POS_W'(path_length_reg);
    assign pop_addr = pcan_pkg::STACK_AW'(stack_count_reg - pcan_pkg::STACK_CW'(1));

    always_comb
    begin
        state_next         = state_reg;
        char_next          = char_reg;
        end_next           = end_reg;
        path_length_next   = path_length_reg;
        stack_count_next   = stack_count_reg;
        comp_length_next   = comp_length_reg;
        comp_kind_next     = comp_kind_reg;
        first_pending_next = first_pending_reg;
        overflow_next      = overflow_reg;
        push_en            = 1'b0;
        pop_en             = 1'b0;
        buf_wr             = '0;
        drain_cmd          = '0;
        wr_pos             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    char_next = item.path_char;
                    end_next  = item.path_end;
                    if (first_pending_reg)
                    begin
                        // drop the leading byte; it stands for the root
                        first_pending_next = 1'b0;
                        if (item.path_end)
                        begin
                            state_next = S_ENDC;
                        end
                    end
                    else if (item.path_char == pcan_pkg::SLASH)
                    begin
                        state_next = S_ENDC;
                    end
                    else
                    begin
                        state_next = S_ADD;
                    end
                end
            end
            S_ADD:
            begin
                if (comp_length_reg == '0)
                begin
                    // open a component: put its separator first
                    buf_wr.en        = (path_length_reg < pcan_pkg::PATH_LW'(pcan_pkg::PATH_BYTES));
                    buf_wr.addr      = path_length_reg[pcan_pkg::PATH_AW-1:0];
                    buf_wr.data      = pcan_pkg::SLASH;
                    comp_length_next = pcan_pkg::COMP_LW'(1);
                end
                else
                begin
                    wr_pos      = pcan_pkg::POS_W'(path_length_reg) + comp_ext;
                    buf_wr.en   = (wr_pos < pcan_pkg::POS_W'(pcan_pkg::PATH_BYTES));
                    buf_wr.addr = wr_pos[pcan_pkg::PATH_AW-1:0];
                    buf_wr.data = char_reg;
                    if (comp_length_reg != COMP_MAX)
                    begin
                        comp_length_next = comp_length_reg + pcan_pkg::COMP_LW'(1);
                    end
                    if (comp_kind_reg == KIND_EMPTY && char_reg == pcan_pkg::DOT)
                    begin
                        comp_kind_next = KIND_DOT;
                    end
                    else if (comp_kind_reg == KIND_DOT && char_reg == pcan_pkg::DOT)
                    begin
                        comp_kind_next = KIND_DOTDOT;
                    end
                    else
                    begin
                        comp_kind_next = KIND_OTHER;
                    end
                    state_next = end_reg ? S_ENDC : S_IDLE;
                end
            end
            S_ENDC:
            begin
                comp_length_next = '0;
                comp_kind_next   = KIND_EMPTY;
                state_next       = S_IDLE;
                if (comp_kind_reg == KIND_DOTDOT && stack_count_reg != '0)
                begin
                    // pop: the old start comes back from the stack next cycle
                    pop_en           = 1'b1;
                    stack_count_next = stack_count_reg - pcan_pkg::STACK_CW'(1);
                    state_next       = S_POP;
                end
                else if (comp_kind_reg == KIND_OTHER)
                begin
                    if (stack_count_reg >= pcan_pkg::STACK_CW'(pcan_pkg::STACK_DEPTH))
                    begin
                        overflow_next = 1'b1;
                    end
                    else if (comp_ext > avail)
                    begin
                        // keep the truncated head if at least one byte fits
                        overflow_next = 1'b1;
                        if (avail >= pcan_pkg::POS_W'(2))
                        begin
                            push_en          = 1'b1;
                            stack_count_next = stack_count_reg + pcan_pkg::STACK_CW'(1);
                            path_length_next = pcan_pkg::PATH_LW'(pcan_pkg::PATH_BYTES);
                        end
                    end
                    else
                    begin
                        push_en          = 1'b1;
                        stack_count_next = stack_count_reg + pcan_pkg::STACK_CW'(1);
                        path_length_next = path_length_reg
                                         + pcan_pkg::PATH_LW'(comp_length_reg);
                    end
                end
                if (end_reg && !pop_en)
                begin
                    drain_cmd = '{go: 1'b1, len: path_length_next, ovf: overflow_next};
                end
            end
            S_POP:
            begin
                path_length_next = pcan_pkg::PATH_LW'(stack_rdata_reg);
                state_next       = S_IDLE;
                if (end_reg)
                begin
                    drain_cmd = '{go: 1'b1, len: path_length_next, ovf: overflow_next};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the finished path to the drain and clear for the next one
        if (drain_cmd.go)
        begin
            path_length_next   = '0;
            stack_count_next   = '0;
            comp_length_next   = '0;
            comp_kind_next     = KIND_EMPTY;
            first_pending_next = 1'b1;
            overflow_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            char_reg          <= '0;
            end_reg           <= 1'b0;
            path_length_reg   <= '0;
            stack_count_reg   <= '0;
            comp_length_reg   <= '0;
            comp_kind_reg     <= KIND_EMPTY;
            first_pending_reg <= 1'b1;
            overflow_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            char_reg          <= char_next;
            end_reg           <= end_next;
            path_length_reg   <= path_length_next;
            stack_count_reg   <= stack_count_next;
            comp_length_reg   <= comp_length_next;
            comp_kind_reg     <= comp_kind_next;
            first_pending_reg <= first_pending_next;
            overflow_reg      <= overflow_next;
        end
    end

    // Push and pop never share a cycle, and a pop always reads an entry
    // written at least one transfer earlier, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[stack_count_reg[pcan_pkg::STACK_AW-1:0]]
                <= path_length_reg[pcan_pkg::PATH_AW-1:0];
        end
        if (pop_en)
        begin
            stack_rdata_reg <= stack_mem[pop_addr];
        end
    end

    pcan_drain u_drain
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (buf_wr),
        .cmd          (drain_cmd),
        .busy         (drain_busy),
        .result_valid (result_valid),
        .result       (result)
    );

    // The drain only runs while the front end sits idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        drain_busy |-> (state_reg == S_IDLE))
        else $error("drain active while front end busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (stack_count_reg <= pcan_pkg::STACK_CW'(pcan_pkg::STACK_DEPTH))
        && (path_length_reg <= pcan_pkg::PATH_LW'(pcan_pkg::PATH_BYTES)))
        else $error("stack count or path length out of range");

    // A finished path is never directly followed by another result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.out_last) |=> !result_valid)
        else $error("result right after the final byte");

    // Handing off a path always leaves the front end cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        drain_cmd.go |=> (first_pending_reg && stack_count_reg == '0
                          && path_length_reg == '0 && !overflow_reg))
        else $error("state not cleared after a path");

endmodule

// File: dv/tb_path_canonicalizer.sv
// Self-checking testbench for the streaming Unix path canonicalizer.
`timescale 1ns / 100ps

module tb_path_canonicalizer;

    localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up
    localparam int RANDOM_ITEMS = 170;

    // Kind of the component being read, as the block classifies it.
    typedef enum logic [1:0] {SEG_EMPTY, SEG_DOT, SEG_DOTDOT, SEG_NAME} seg_kind_t;

    // Shapes of random paths: ordinary, raw noise, many short components,
    // and one component long enough to run into the end of the buffer.
    typedef enum {SHAPE_NORMAL, SHAPE_NOISE, SHAPE_DEEP, SHAPE_LONG} path_shape_t;

    typedef logic [7:0] path_bytes_t [$];

    // Canonical path predictor and the queue of bytes it still waits for.
    class path_scoreboard_t;
        logic [7:0]                   text [pcan_pkg::PATH_BYTES];
        logic [pcan_pkg::PATH_AW-1:0] seg_start [pcan_pkg::STACK_DEPTH];
        int unsigned                  path_len;
        int unsigned                  kept_count;
        int unsigned                  seg_len;
        seg_kind_t                    seg_kind;
        bit                           skip_first;
        bit                           lost;
        pcan_pkg::result_t            canon_q [$];
        int                           results_seen;
        int                           errors;

        function new();
            clear_path();
            results_seen = 0;
            errors = 0;
        endfunction

        function void clear_path();
            path_len   = 0;
            kept_count = 0;
            seg_len    = 0;
            seg_kind   = SEG_EMPTY;
            skip_first = 1'b1;
            lost       = 1'b0;
        endfunction

        function int pending();
            return canon_q.size();
        endfunction

        function void put_char(int unsigned pos, logic [7:0] c);
            if (pos < pcan_pkg::PATH_BYTES)
                text[pos] = c;
        endfunction

        function void append_char(logic [7:0] c);
            if (seg_len == 0)
            begin
                put_char(path_len, pcan_pkg::SLASH);
                seg_len = 1;
            end
            put_char(path_len + seg_len, c);
            if (seg_len < 127)
                seg_len++;
            if (seg_kind == SEG_EMPTY && c == pcan_pkg::DOT)
                seg_kind = SEG_DOT;
            else if (seg_kind == SEG_DOT && c == pcan_pkg::DOT)
                seg_kind = SEG_DOTDOT;
            else
                seg_kind = SEG_NAME;
        endfunction

        // Close the current component: pop on "..", push a name if it fits, else its head.
        function void close_segment();
            int unsigned room;
            room = (path_len < pcan_pkg::PATH_BYTES) ? pcan_pkg::PATH_BYTES - path_len : 0;
            if (seg_kind == SEG_DOTDOT)
            begin
                if (kept_count > 0)
                begin
                    kept_count--;
                    path_len = seg_start[kept_count];
                end
            end
            else if (seg_kind == SEG_NAME)
            begin
                if (kept_count >= pcan_pkg::STACK_DEPTH)
                    lost = 1'b1;
                else if (seg_len > room)
                begin
                    // keep the part that fits, unless not even one byte does
                    lost = 1'b1;
                    if (room >= 2)
                    begin
                        seg_start[kept_count] = pcan_pkg::PATH_AW'(path_len);
                        kept_count++;
                        path_len = pcan_pkg::PATH_BYTES;
                    end
                end
                else
                begin
                    seg_start[kept_count] = pcan_pkg::PATH_AW'(path_len);
                    kept_count++;
                    path_len += seg_len;
                end
            end
            seg_len  = 0;
            seg_kind = SEG_EMPTY;
        endfunction

        function void note_input(pcan_pkg::item_t it);
            pcan_pkg::result_t r;
            int unsigned       n;
            if (skip_first)
                skip_first = 1'b0;
            else if (it.path_char == pcan_pkg::SLASH)
                close_segment();
            else
                append_char(it.path_char);
            if (!it.path_end)
                return;
            close_segment();
            r.overflowed = lost;
            if (path_len == 0)
            begin
                r.out_char = pcan_pkg::SLASH;
                r.out_last = 1'b1;
                canon_q = {canon_q, r};
            end
            else
            begin
                n = (path_len < pcan_pkg::PATH_BYTES) ? path_len : pcan_pkg::PATH_BYTES;
                for (int unsigned i = 0; i < n; i++)
                begin
                    r.out_char = text[i];
                    r.out_last = (i + 1 == n);
                    canon_q = {canon_q, r};
                end
            end
            clear_path();
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", results_seen, msg);
            errors++;
        endtask

        task check_result(pcan_pkg::result_t got);
            pcan_pkg::result_t want;
            if (canon_q.size() == 0)
                report($sformatf("byte 0x%02h with nothing outstanding", got.out_char));
            else
            begin
                want = canon_q.pop_front();
                if (got.out_char !== want.out_char)
                    report($sformatf("out_char 0x%02h, want 0x%02h",
                                     got.out_char, want.out_char));
                if (got.out_last !== want.out_last)
                    report($sformatf("out_last %b, want %b", got.out_last, want.out_last));
                if (got.overflowed !== want.overflowed)
                    report($sformatf("overflowed %b, want %b",
                                     got.overflowed, want.overflowed));
            end
            results_seen++;
        endtask
    endclass

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    pcan_pkg::item_t   item  = '0;
    logic              busy;
    logic              result_valid;
    pcan_pkg::result_t result;

    path_scoreboard_t sb = new();
    bit quiet = 1'b0;       // set to hold the sender back from idling
    int stall_cycles = 0;

    path_canonicalizer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample both sides at the edge that completes the transfer. Check the
    // result first; no result can stem from a byte taken at the same edge.
    // The watchdog counts edges at which neither side moves anything.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(result);
            if (start && !busy)
                sb.note_input(item);
            if (result_valid || (start && !busy))
                stall_cycles = 0;
            else if (++stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Any byte except '/', with dots favored so that ".", ".." and names
    // made of dots show up often.
    function automatic logic [7:0] rand_name_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == pcan_pkg::SLASH || $urandom_range(0, 4) == 0)
            c = pcan_pkg::DOT;
        return c;
    endfunction

    function automatic path_bytes_t text_bytes(string s);
        path_bytes_t q;
        for (int i = 0; i < s.len(); i++)
            q = {q, s[i]};
        return q;
    endfunction

    // Drive one path, byte by byte, marking the final byte. Called at a
    // rising edge; returns at the edge that takes the final byte. Start
    // stays high between back-to-back bytes and drops only for an idle gap.
    task automatic send_path(input path_bytes_t bytes_in);
        pcan_pkg::item_t next;
        foreach (bytes_in[i])
        begin
            if (!quiet && $urandom_range(0, 99) < 7)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            next.path_char = bytes_in[i];
            next.path_end  = (i == bytes_in.size() - 1);
            start <= 1'b1;
            item  <= next;
            do @(posedge clk); while (busy);
        end
    endtask

    // Hold the sender off until every outstanding byte has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial
    begin
        path_bytes_t path;
        path_shape_t shape;
        int          random_items;
        int          n_comps;
        int          len;
        int          pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed paths: a lone first byte that also ends the path, the
        // usual mix of ".", ".." and a trailing '/', ".." with nothing kept,
        // an empty component, and extreme byte values inside a name.
        path = {8'hFF};
        send_path(path);
        send_path(text_bytes("/a/./b/../c/"));
        send_path(text_bytes("/../"));
        send_path(text_bytes("//"));
        path = {pcan_pkg::SLASH, 8'h00, 8'hFF, pcan_pkg::SLASH,
                pcan_pkg::DOT, pcan_pkg::DOT, pcan_pkg::DOT};
        send_path(path);
        wait_drained();

        random_items = 0;
        for (int p = 0; random_items < RANDOM_ITEMS; p++)
        begin
            // leave a long stretch free of idle gaps
            quiet = (random_items >= 80 && random_items < 160);
            if (p % 12 == 5)
                shape = SHAPE_DEEP;
            else if (p % 12 == 9)
                shape = SHAPE_LONG;
            else if ($urandom_range(0, 99) < 20)
                shape = SHAPE_NOISE;
            else
                shape = SHAPE_NORMAL;

            path.delete();
            path = {path, ($urandom_range(0, 99) < 85) ? pcan_pkg::SLASH
                                                       : 8'($urandom_range(0, 255))};
            case (shape)
                SHAPE_NORMAL:
                begin
                    n_comps = $urandom_range(0, 6);
                    for (int c = 0; c < n_comps; c++)
                    begin
                        if (c > 0)
                            path = {path, pcan_pkg::SLASH};
                        pick = $urandom_range(0, 99);
                        if (pick < 15)
                            ;   // empty component
                        else if (pick < 30)
                            path = {path, pcan_pkg::DOT};
                        else if (pick < 45)
                        begin
                            path = {path, pcan_pkg::DOT, pcan_pkg::DOT};
                        end
                        else
                        begin
                            len = $urandom_range(1, 6);
                            repeat (len) path = {path, rand_name_byte()};
                        end
                    end
                    if ($urandom_range(0, 99) < 30)
                        path = {path, pcan_pkg::SLASH};
                end
                SHAPE_NOISE:
                begin
                    len = $urandom_range(1, 12);
                    repeat (len)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 30)
                            path = {path, pcan_pkg::SLASH};
                        else if (pick < 50)
                            path = {path, pcan_pkg::DOT};
                        else
                            path = {path, 8'($urandom_range(0, 255))};
                    end
                end
                SHAPE_DEEP:
                begin
                    // one-byte names that come near the start stack depth or overrun it
                    n_comps = $urandom_range(30, 36);
                    for (int c = 0; c < n_comps; c++)
                    begin
                        if (c > 0)
                            path = {path, pcan_pkg::SLASH};
                        if ($urandom_range(0, 9) == 0)
                        begin
                            path = {path, pcan_pkg::DOT, pcan_pkg::DOT};
                        end
                        else
                            path = {path, rand_name_byte()};
                    end
                end
                SHAPE_LONG:
                begin
                    // a name near or past the buffer size, then short ones
                    // that land on a partly full or a full buffer
                    len = $urandom_range(56, 70);
                    repeat (len) path = {path, rand_name_byte()};
                    n_comps = $urandom_range(1, 4);
                    repeat (n_comps)
                    begin
                        path = {path, pcan_pkg::SLASH};
                        if ($urandom_range(0, 3) == 0)
                        begin
                            path = {path, pcan_pkg::DOT, pcan_pkg::DOT};
                        end
                        else
                        begin
                            len = $urandom_range(1, 4);
                            repeat (len) path = {path, rand_name_byte()};
                        end
                    end
                end
                default:
                begin
                end
            endcase

            send_path(path);
            random_items += path.size();
            if (p % 10 == 0)
                wait_drained();
        end

        // Let the last drain finish, then allow the block its tail latency.
        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/core/pcan_pkg.sv
rtl/core/pcan_drain.sv
rtl/core/path_canonicalizer.sv
dv/tb_path_canonicalizer.sv
